// ===== sv/grid_line_of_sight_core_macros.svh =====
// Assertion macros shared by the grid line-of-sight RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef GRID_LINE_OF_SIGHT_CORE_MACROS_SVH
`define GRID_LINE_OF_SIGHT_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define GLOS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid line-of-sight: implication check failed");

`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid line-of-sight: next-cycle check failed");

`define GLOS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("grid line-of-sight: forbidden condition seen");

`else

`define GLOS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`define GLOS_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== sv/glos_pkg.sv =====
// Shared types, constants and helpers for the grid line-of-sight core.
// No dependencies; every module of the block imports this package.
package glos_pkg;

    localparam int MAX_GRID_WIDTH  = 512;
    localparam int MAX_GRID_HEIGHT = 512;
    localparam int GRID_DEPTH      = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
    localparam int GRID_AW         = $clog2(GRID_DEPTH);

    localparam int COORD_W    = 9;
    localparam int COST_W     = 8;
    localparam int THR_W      = 9;
    localparam int SIZE_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 9'd150;
    localparam logic [SIZE_W-1:0] SIZE_RESET      = 10'd512;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COST_W-1:0]  cell_cost;
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
    } glos_item_t;

    typedef struct packed {
        logic answer_kind;
        logic in_sight;
    } glos_result_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SIZE_W-1:0] eff_width;
        logic [SIZE_W-1:0] eff_height;
    } glos_cfg_t;

    typedef struct packed {
        logic               en0;
        logic [GRID_AW-1:0] addr0;
        logic               en1;
        logic [GRID_AW-1:0] addr1;
    } glos_rd_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic in_sight;
    } glos_walk_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN
    } glos_state_t;

    // Row-major cell address; the multiply is by a constant.
    function automatic logic [GRID_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        cell_addr = GRID_AW'(GRID_AW'(y) * GRID_AW'(MAX_GRID_WIDTH) + GRID_AW'(x));
    endfunction

endpackage

// ===== sv/glos_grid_mem.sv =====
// Cost grid storage: one write port and two registered read ports.
// Depends on glos_pkg for depth, address width and the read request type.
module glos_grid_mem
    import glos_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [GRID_AW-1:0] wr_addr,
    input  logic [COST_W-1:0]  wr_data,
    input  glos_rd_req_t       rd_req,
    output logic [COST_W-1:0]  rd_data0,
    output logic [COST_W-1:0]  rd_data1
);

    logic [COST_W-1:0] grid_mem [GRID_DEPTH];
    logic [COST_W-1:0] rd_data0_reg;
    logic [COST_W-1:0] rd_data1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_req.en0)
        begin
            rd_data0_reg <= grid_mem[rd_req.addr0];
        end
        if (rd_req.en1)
        begin
            rd_data1_reg <= grid_mem[rd_req.addr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

// ===== sv/glos_walker.sv =====
// Line walk sequencer: one step per cycle, up to two grid reads per step,
// cost compare in the next cycle. Depends on glos_pkg and the assertion macros.
`include "grid_line_of_sight_core_macros.svh"

module glos_walker
    import glos_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  glos_item_t        item,
    input  glos_cfg_t         cfg,
    output glos_rd_req_t      rd_req,
    input  logic [COST_W-1:0] rd_data0,
    input  logic [COST_W-1:0] rd_data1,
    output glos_walk_status_t status
);

    glos_state_t state_reg, state_next;
    glos_item_t  qry_reg;

    // Walk state in major/minor axis terms.
    logic [COORD_W-1:0] p_reg, p_next;
    logic [COORD_W-1:0] q_reg, q_next;
    logic [COORD_W-1:0] p_end_reg, p_end_next;
    logic [COORD_W-1:0] dmaj_reg, dmaj_next;
    logic [COORD_W-1:0] dmin_reg, dmin_next;
    logic [COORD_W-1:0] err_reg, err_next;
    logic ymaj_reg, ymaj_next;
    logic maj_neg_reg, maj_neg_next;
    logic min_neg_reg, min_neg_next;
    logic pair_reg, pair_next;

    // Check stage, aligned with the read data.
    logic       chk_valid_reg, chk_valid_next;
    logic       chk_pair_reg;
    logic [1:0] chk_en_reg;
    logic [1:0] chk_inb_reg;

    // Setup terms.
    logic [COORD_W-1:0] dx_abs, dy_abs;
    logic               neg_x, neg_y, ymaj_s;

    // Step terms.
    logic [COORD_W:0]   e1, e2;
    logic               step_min;
    logic [COORD_W-1:0] q2, p_step;
    logic [COORD_W:0]   maj_c, min0_c, min1_c;
    logic [COORD_W:0]   x0_c, y0_c, x1_c, y1_c;
    logic [1:0]         iss_en, iss_inb;
    logic               issue;

    // Evaluation terms.
    logic blk0, blk1, blocked_e;

    function automatic logic in_bounds(input logic [COORD_W:0]  c,
                                       input logic [SIZE_W-1:0] lim);
        in_bounds = !c[COORD_W] && (c[COORD_W-1:0] != '0)
                    && (SIZE_W'(c[COORD_W-1:0]) < lim);
    endfunction

    always_comb
    begin
        neg_x  = qry_reg.to_x < qry_reg.from_x;
        neg_y  = qry_reg.to_y < qry_reg.from_y;
        dx_abs = neg_x ? qry_reg.from_x - qry_reg.to_x : qry_reg.to_x - qry_reg.from_x;
        dy_abs = neg_y ? qry_reg.from_y - qry_reg.to_y : qry_reg.to_y - qry_reg.from_y;
        ymaj_s = dx_abs < dy_abs;
    end

    always_comb
    begin
        e1       = {1'b0, err_reg} + {1'b0, dmin_reg};
        step_min = e1 >= {1'b0, dmaj_reg};
        e2       = step_min ? e1 - {1'b0, dmaj_reg} : e1;
        q2       = step_min ? (min_neg_reg ? q_reg - COORD_W'(1) : q_reg + COORD_W'(1))
                            : q_reg;
        p_step   = maj_neg_reg ? p_reg - COORD_W'(1) : p_reg + COORD_W'(1);

        // A negative step looks at the cell one below the corner.
        maj_c = {1'b0, p_reg} - {{COORD_W{1'b0}}, maj_neg_reg};
        if (pair_reg)
        begin
            min0_c = {1'b0, q_reg};
            min1_c = {1'b0, q_reg} - {{COORD_W{1'b0}}, 1'b1};
        end
        else
        begin
            min0_c = {1'b0, q_reg} - {{COORD_W{1'b0}}, min_neg_reg};
            min1_c = {1'b0, q2} - {{COORD_W{1'b0}}, min_neg_reg};
        end

        x0_c = ymaj_reg ? min0_c : maj_c;
        y0_c = ymaj_reg ? maj_c : min0_c;
        x1_c = ymaj_reg ? min1_c : maj_c;
        y1_c = ymaj_reg ? maj_c : min1_c;

        iss_en[0]  = pair_reg || step_min;
        iss_en[1]  = pair_reg || (e2 != '0);
        iss_inb[0] = in_bounds(x0_c, cfg.eff_width) && in_bounds(y0_c, cfg.eff_height);
        iss_inb[1] = in_bounds(x1_c, cfg.eff_width) && in_bounds(y1_c, cfg.eff_height);

        issue        = state_reg == ST_RUN;
        rd_req.en0   = issue && iss_en[0] && iss_inb[0];
        rd_req.en1   = issue && iss_en[1] && iss_inb[1];
        rd_req.addr0 = cell_addr(x0_c[COORD_W-1:0], y0_c[COORD_W-1:0]);
        rd_req.addr1 = cell_addr(x1_c[COORD_W-1:0], y1_c[COORD_W-1:0]);
    end

    always_comb
    begin
        blk0 = !chk_inb_reg[0] || ({1'b0, rd_data0} >= cfg.threshold);
        blk1 = !chk_inb_reg[1] || ({1'b0, rd_data1} >= cfg.threshold);
        if (chk_pair_reg)
        begin
            // Along an axis-parallel edge only both neighbors together block.
            blocked_e = chk_valid_reg && blk0 && blk1;
        end
        else
        begin
            blocked_e = chk_valid_reg
                        && ((chk_en_reg[0] && blk0) || (chk_en_reg[1] && blk1));
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        p_end_next      = p_end_reg;
        dmaj_next       = dmaj_reg;
        dmin_next       = dmin_reg;
        err_next        = err_reg;
        ymaj_next       = ymaj_reg;
        maj_neg_next    = maj_neg_reg;
        min_neg_next    = min_neg_reg;
        pair_next       = pair_reg;
        chk_valid_next  = 1'b0;
        status.busy     = state_reg != ST_IDLE;
        status.done     = 1'b0;
        status.in_sight = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                p_next       = ymaj_s ? qry_reg.from_y : qry_reg.from_x;
                q_next       = ymaj_s ? qry_reg.from_x : qry_reg.from_y;
                p_end_next   = ymaj_s ? qry_reg.to_y : qry_reg.to_x;
                dmaj_next    = ymaj_s ? dy_abs : dx_abs;
                dmin_next    = ymaj_s ? dx_abs : dy_abs;
                maj_neg_next = ymaj_s ? neg_y : neg_x;
                min_neg_next = ymaj_s ? neg_x : neg_y;
                ymaj_next    = ymaj_s;
                pair_next    = ymaj_s ? (dx_abs == '0) : (dy_abs == '0);
                err_next     = '0;
                if ((dx_abs == '0) && (dy_abs == '0))
                begin
                    // Start equals end: nothing to check.
                    status.done     = 1'b1;
                    status.in_sight = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (blocked_e)
                begin
                    status.done = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    chk_valid_next = 1'b1;
                    p_next         = p_step;
                    q_next         = q2;
                    err_next       = e2[COORD_W-1:0];
                    if (p_step == p_end_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                status.done     = 1'b1;
                status.in_sight = !blocked_e;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
        begin
            qry_reg <= item;
        end
        p_reg        <= p_next;
        q_reg        <= q_next;
        p_end_reg    <= p_end_next;
        dmaj_reg     <= dmaj_next;
        dmin_reg     <= dmin_next;
        err_reg      <= err_next;
        ymaj_reg     <= ymaj_next;
        maj_neg_reg  <= maj_neg_next;
        min_neg_reg  <= min_neg_next;
        pair_reg     <= pair_next;
        chk_pair_reg <= pair_reg;
        chk_en_reg   <= iss_en;
        chk_inb_reg  <= iss_inb;
    end

    `GLOS_ASSERT_NEXT(a_done_returns_idle, clk, rst_n, status.done, state_reg == ST_IDLE)
    `GLOS_ASSERT_IMPLIES(a_check_follows_run, clk, rst_n, chk_valid_reg, $past(state_reg == ST_RUN))
    `GLOS_ASSERT_IMPLIES(a_drain_has_check, clk, rst_n, state_reg == ST_DRAIN, chk_valid_reg)

endmodule

// ===== sv/grid_line_of_sight_core.sv =====
// Top level of the grid line-of-sight core: command port, register file,
// result register. Depends on glos_pkg, glos_grid_mem, glos_walker and the macros.
//
// Usage:
//   Items enter on start/item and are taken at an edge where start is high and
//   busy is low. A write item (cmd = 0) stores one cell cost; a query item
//   (cmd = 1) tests line of sight between two cell corners. Every item gives
//   one result word on result, shown for exactly one cycle with done high.
//   A write is acknowledged in the cycle after it is taken and leaves busy low. A query
//   holds busy through setup, stepping and drain, or setup alone when start and end
//   coincide; its answer shows in the cycle where busy goes low. A blocking cell ends
//   the walk early. The walker issues one line step per cycle, served by the two read
//   ports of the grid memory with the cost compare in the following cycle. busy is low
//   while the answer is shown, so the next item may be taken in that cycle. Registers
//   are written over cfg_valid/cfg_ready/cfg_index/cfg_data while no item is in
//   flight; the user must ensure this, the block does not. cfg_ready is always high and
//   unknown indexes are ignored. Reset sets the threshold to 150 and both grid sizes to
//   512. The grid itself is not cleared: a cell must be written before a query looks at
//   it. There is no result back-pressure; the receiver takes each word as it appears.
`include "grid_line_of_sight_core_macros.svh"

module grid_line_of_sight_core
    import glos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  glos_item_t            item,
    output logic                  done,
    output glos_result_t          result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [THR_W-1:0]  threshold_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    glos_cfg_t         cfg;
    glos_rd_req_t      rd_req;
    glos_walk_status_t walk_status;
    logic [COST_W-1:0] rd_data0, rd_data1;

    logic         accept, write_accept, query_accept, wr_en;
    logic         done_reg, done_next;
    glos_result_t result_reg, result_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= SIZE_RESET;
            height_reg    <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                CFG_WIDTH:     width_reg     <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:    height_reg    <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.threshold  = threshold_reg;
        cfg.eff_width  = (32'(width_reg) > MAX_GRID_WIDTH)
                         ? SIZE_W'(MAX_GRID_WIDTH) : width_reg;
        cfg.eff_height = (32'(height_reg) > MAX_GRID_HEIGHT)
                         ? SIZE_W'(MAX_GRID_HEIGHT) : height_reg;
    end

    // Writes only land while the walker is idle, so reads never race them.
    assign busy         = walk_status.busy;
    assign accept       = start && !busy;
    assign write_accept = accept && (item.cmd == CMD_WRITE);
    assign query_accept = accept && (item.cmd == CMD_QUERY);
    assign wr_en        = write_accept
                          && (32'(item.cell_x) < MAX_GRID_WIDTH)
                          && (32'(item.cell_y) < MAX_GRID_HEIGHT);

    glos_grid_mem u_grid_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (cell_addr(item.cell_x, item.cell_y)),
        .wr_data  (item.cell_cost),
        .rd_req   (rd_req),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    glos_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (query_accept),
        .item     (item),
        .cfg      (cfg),
        .rd_req   (rd_req),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1),
        .status   (walk_status)
    );

    always_comb
    begin
        done_next   = write_accept || walk_status.done;
        result_next = result_reg;
        if (walk_status.done)
        begin
            result_next.answer_kind = KIND_QUERY;
            result_next.in_sight    = walk_status.in_sight;
        end
        else if (write_accept)
        begin
            result_next.answer_kind = KIND_ACK;
            result_next.in_sight    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `GLOS_ASSERT_NEVER(a_no_word_while_busy, clk, rst_n, done_reg && busy)
    `GLOS_ASSERT_NEXT(a_query_goes_busy, clk, rst_n, query_accept, busy)
    `GLOS_ASSERT_NEXT(a_write_acked, clk, rst_n, write_accept, done_reg && (result_reg.answer_kind == KIND_ACK))

endmodule
